FILE: rtl/lpht_pkg.sv
// shared types and constants for the linear probing hash table
`default_nettype none

package lpht_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam logic [4:0] DIVISOR_RESET = 5'd11;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_key;
    logic [3:0]  slot;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic probe_init;
    logic probe_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rem_done;
    logic probe_stop;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/linear_probe_hash_table_unit.sv
// top level of the linear probing hash table
//
// channel   dir  handshake             payload
// in        in   in_valid / in_ready   in_data   (command, key)
// out       out  out_valid / out_ready out_data  (status, found_key, slot)
// cfg       in   cfg_we                cfg_data  (divisor, 5 bits)
//
// one request at a time: accept, then key modulo divisor
// (4 key bits a cycle), then a probe over at most d slots, then commit
// the probe reads one slot a cycle, so the active slot count d sets the spread
// rst is synchronous: all slots empty, divisor 11, no result pending
// a new request is taken while the last result waits; the commit holds until it transfers
`default_nettype none

module linear_probe_hash_table_unit #(
  parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lpht_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lpht_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [4:0]          cfg_data
);

  lpht_pkg::ctrl_cmd_t  cmd;
  lpht_pkg::dp_status_t sts;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/lpht_rem.sv
// iterative key modulo divisor unit, four quotient bits per cycle
`default_nettype none

module lpht_rem (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] key,
  input  wire logic [4:0]  d,
  output logic             done,
  output logic [4:0]       rem
);

  localparam int RADIX_BITS = 4;
  localparam int STEPS      = 32 / RADIX_BITS;
  localparam int CW         = $clog2(STEPS);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [31:0]   shreg;
  logic [4:0]    rem_step;

  // restoring steps: partial remainder stays below d, so six bits hold the shifted value
  always_comb begin
    logic [5:0] t;
    logic [4:0] r_v;
    r_v = rem;
    for (int i = 0; i < RADIX_BITS; i++) begin
      t = {r_v, shreg[31 - i]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      r_v = t[4:0];
    end
    rem_step = r_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= key;
    end else if (busy) begin
      rem   <= rem_step;
      shreg <= shreg << RADIX_BITS;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lpht_dp.sv
// datapath: divisor register, request latch, probe index, key store and empty flags
`default_nettype none

module lpht_dp #(
  parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lpht_pkg::ctrl_cmd_t  cmd,
  output lpht_pkg::dp_status_t      sts,
  input  wire logic                 cfg_we,
  input  wire logic [4:0]           cfg_data,
  input  wire lpht_pkg::in_item_t   in_data,
  output lpht_pkg::out_item_t       out_data
);

  // a 5-bit divisor never reaches slots above 30
  localparam int USED_DEPTH = (TABLE_DEPTH < 31) ? TABLE_DEPTH : 31;
  localparam int IW         = $clog2(USED_DEPTH);

  logic [4:0]            divisor;
  logic [4:0]            d;
  lpht_pkg::in_item_t    req;
  logic [IW-1:0]         home;
  logic [IW-1:0]         j;
  logic [IW-1:0]         j_inc;
  logic [4:0]            n;
  logic [31:0]           key_store [USED_DEPTH];
  logic [USED_DEPTH-1:0] slot_empty;
  logic                  rem_done;
  logic [4:0]            rem_value;
  logic                  cur_empty;
  logic                  cur_match;
  logic                  hit;
  logic                  last;
  lpht_pkg::out_item_t   res;

  // clamp the divisor to 1..TABLE_DEPTH
  always_comb begin
    if (divisor == 5'd0) begin
      d = 5'd1;
    end else if (32'(divisor) > TABLE_DEPTH) begin
      d = 5'(TABLE_DEPTH);
    end else begin
      d = divisor;
    end
  end

  lpht_rem u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.load),
    .key   (in_data.key),
    .d     (d),
    .done  (rem_done),
    .rem   (rem_value)
  );

  assign cur_empty = slot_empty[j];
  assign cur_match = (key_store[j] == req.key);
  assign hit       = !cur_empty && cur_match;
  assign last      = (n == d - 5'd1);
  assign j_inc     = (6'(j) + 6'd1 == 6'(d)) ? '0 : j + IW'(1);

  assign sts.rem_done   = rem_done;
  assign sts.probe_stop = cur_empty || cur_match || last;

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= lpht_pkg::DIVISOR_RESET;
    end else if (cfg_we) begin
      divisor <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_data;
    end
    if (cmd.probe_init) begin
      home <= IW'(rem_value);
      j    <= IW'(rem_value);
      n    <= '0;
    end else if (cmd.probe_step) begin
      if (!(cur_empty || cur_match)) begin
        // a full lap ends back on the home slot
        j <= last ? home : j_inc;
      end
      n <= n + 5'd1;
    end
  end

  always_comb begin
    res.status    = lpht_pkg::ST_NOT_FOUND;
    res.found_key = '0;
    res.slot      = 4'(j);
    case (req.command)
      lpht_pkg::CMD_INSERT: begin
        if (cur_empty) begin
          res.status = lpht_pkg::ST_DONE;
        end else if (cur_match) begin
          res.status = lpht_pkg::ST_DUPLICATE;
        end else begin
          res.status = lpht_pkg::ST_FULL;
        end
      end
      lpht_pkg::CMD_SEARCH: begin
        if (hit) begin
          res.status    = lpht_pkg::ST_DONE;
          res.found_key = req.key;
        end
      end
      lpht_pkg::CMD_DELETE: begin
        if (hit) begin
          res.status = lpht_pkg::ST_DONE;
        end
      end
      default: begin
        res.slot = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && req.command == lpht_pkg::CMD_INSERT && cur_empty) begin
      key_store[j] <= req.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_empty <= '1;
    end else if (cmd.commit) begin
      if (req.command == lpht_pkg::CMD_INSERT && cur_empty) begin
        slot_empty[j] <= 1'b0;
      end else if (req.command == lpht_pkg::CMD_DELETE && hit) begin
        slot_empty[j] <= 1'b1;
      end
    end
  end

  a_probe_in_lap: assert property (@(posedge clk) disable iff (rst)
    cmd.probe_step |-> (n < d))
    else $error("probe count ran past one lap");

  a_insert_fills: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && req.command == lpht_pkg::CMD_INSERT && cur_empty)
    |=> !slot_empty[$past(j)])
    else $error("stored insert left its slot empty");

endmodule

`default_nettype wire

FILE: rtl/lpht_ctrl.sv
// controller state machine: modulo, probe and commit sequencing, output valid
`default_nettype none

module lpht_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire lpht_pkg::dp_status_t sts,
  output lpht_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MOD   = 4'b0010,
    S_PROBE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd.load       = 1'b0;
    cmd.probe_init = 1'b0;
    cmd.probe_step = 1'b0;
    cmd.commit     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.rem_done) begin
          cmd.probe_init = 1'b1;
          state_next     = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe_step = 1'b1;
        if (sts.probe_stop) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // wait until the result register is free
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");

  a_load_to_mod: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MOD))
    else $error("accepted request did not start modulo");

  a_rem_in_mod: assert property (@(posedge clk) disable iff (rst)
    sts.rem_done |-> (state == S_MOD))
    else $error("modulo finished outside its state");

endmodule

`default_nettype wire

FILE: tb/sv/linear_probe_hash_table_unit_tb.sv
// testbench for the linear probing hash table: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module linear_probe_hash_table_unit_tb;

  localparam int TABLE_SLOTS = lpht_pkg::TABLE_DEPTH_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 30;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  lpht_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  lpht_pkg::out_item_t out_data;
  logic cfg_we;
  logic [4:0] cfg_data;

  // predictor state
  logic [31:0] shadow_keys [TABLE_SLOTS];
  bit shadow_vacant [TABLE_SLOTS];
  logic [4:0] shadow_divisor;

  lpht_pkg::out_item_t expected_results [$];
  int mismatch_count;
  int idle_cycles;
  bit pace_enable;
  int burst_left;
  int rx_run_left;

  linear_probe_hash_table_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int unsigned effective_span(logic [4:0] div);
    if (div == 5'd0) return 1;
    if (div > TABLE_SLOTS) return TABLE_SLOTS;
    return div;
  endfunction

  function automatic lpht_pkg::out_item_t predict_response(lpht_pkg::in_item_t req);
    lpht_pkg::out_item_t rsp;
    int unsigned span;
    int unsigned idx;
    int unsigned stop_at;
    int unsigned n;
    bit stopped;
    rsp.status = lpht_pkg::ST_NOT_FOUND;
    rsp.found_key = '0;
    rsp.slot = '0;
    if (req.command == CMD_UNUSED) return rsp;
    span = effective_span(shadow_divisor);
    idx = req.key % span;
    // a full lap with no stop leaves the probe on the home slot
    stop_at = idx;
    stopped = 1'b0;
    for (n = 0; n < span; n++) begin
      if (!stopped && (shadow_vacant[idx] || shadow_keys[idx] == req.key)) begin
        stop_at = idx;
        stopped = 1'b1;
      end
      idx = (idx + 1 == span) ? 0 : idx + 1;
    end
    rsp.slot = stop_at[3:0];
    case (req.command)
      lpht_pkg::CMD_INSERT: begin
        if (shadow_vacant[stop_at]) begin
          shadow_vacant[stop_at] = 1'b0;
          shadow_keys[stop_at] = req.key;
          rsp.status = lpht_pkg::ST_DONE;
        end else if (shadow_keys[stop_at] == req.key) begin
          rsp.status = lpht_pkg::ST_DUPLICATE;
        end else begin
          rsp.status = lpht_pkg::ST_FULL;
        end
      end
      lpht_pkg::CMD_SEARCH: begin
        if (!shadow_vacant[stop_at] && shadow_keys[stop_at] == req.key) begin
          rsp.status = lpht_pkg::ST_DONE;
          rsp.found_key = shadow_keys[stop_at];
        end
      end
      lpht_pkg::CMD_DELETE: begin
        if (!shadow_vacant[stop_at] && shadow_keys[stop_at] == req.key) begin
          shadow_keys[stop_at] = '0;
          shadow_vacant[stop_at] = 1'b1;
          rsp.status = lpht_pkg::ST_DONE;
        end
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] key);
    lpht_pkg::in_item_t item;
    if (pace_enable && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    item.command = cmd;
    item.key = key;
    in_data = item;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_response(item));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_divisor(input logic [4:0] value);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_data = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    shadow_divisor = value;
  endtask

  task automatic test_basic_operations();
    // divisor 11 from reset: build a chain on home slot 0, then break it
    send_request(lpht_pkg::CMD_INSERT, 32'd0);
    send_request(lpht_pkg::CMD_INSERT, 32'd11);
    send_request(lpht_pkg::CMD_INSERT, 32'd22);
    send_request(lpht_pkg::CMD_INSERT, 32'd0);
    send_request(lpht_pkg::CMD_SEARCH, 32'd22);
    send_request(lpht_pkg::CMD_SEARCH, 32'd33);
    send_request(lpht_pkg::CMD_DELETE, 32'd11);
    // the hole left by the delete hides 22
    send_request(lpht_pkg::CMD_SEARCH, 32'd22);
    send_request(lpht_pkg::CMD_DELETE, 32'd22);
    send_request(lpht_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_request(lpht_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
    send_request(lpht_pkg::CMD_INSERT, 32'h8000_0000);
    send_request(lpht_pkg::CMD_INSERT, 32'h7FFF_FFFF);
    send_request(lpht_pkg::CMD_DELETE, 32'h8000_0000);
    send_request(CMD_UNUSED, 32'hFFFF_FFFF);
  endtask

  task automatic test_divisor_extremes();
    write_divisor(5'd1);
    send_request(lpht_pkg::CMD_DELETE, 32'd0);
    send_request(lpht_pkg::CMD_INSERT, 32'hAAAA_AAAA);
    send_request(lpht_pkg::CMD_INSERT, 32'h5555_5555);
    send_request(lpht_pkg::CMD_SEARCH, 32'h5555_5555);
    send_request(lpht_pkg::CMD_INSERT, 32'hAAAA_AAAA);
    // zero acts as one
    write_divisor(5'd0);
    send_request(lpht_pkg::CMD_SEARCH, 32'hAAAA_AAAA);
    // above the table depth saturates, stored keys stay where they are
    write_divisor(5'd31);
    send_request(lpht_pkg::CMD_SEARCH, 32'hAAAA_AAAA);
    send_request(lpht_pkg::CMD_INSERT, 32'd32);
  endtask

  task automatic test_random_traffic();
    logic [4:0] phase_divisors [10] = '{5'd16, 5'd5, 5'd1, 5'd0, 5'd31,
                                        5'd11, 5'd17, 5'd3, 5'd16, 5'd2};
    logic [31:0] key_pool [24];
    int pool_size;
    int unsigned span;
    int pick;
    logic [1:0] cmd;
    logic [31:0] key;
    for (int p = 0; p < 10; p++) begin
      write_divisor(phase_divisors[p]);
      pace_enable = (p % 4 != 2);
      span = effective_span(shadow_divisor);
      pool_size = $urandom_range(4, 24);
      // part of the pool shares one home slot to grow long probe chains
      for (int i = 0; i < pool_size; i++) begin
        if (i < pool_size / 2)
          key_pool[i] = span * $urandom_range(0, 32'h0FFF_FFFF) + (p % span);
        else
          key_pool[i] = $urandom();
      end
      for (int i = 0; i < 55; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) cmd = lpht_pkg::CMD_INSERT;
        else if (pick < 72) cmd = lpht_pkg::CMD_SEARCH;
        else if (pick < 95) cmd = lpht_pkg::CMD_DELETE;
        else cmd = CMD_UNUSED;
        if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, pool_size - 1)];
        else key = $urandom();
        send_request(cmd, key);
        if ($urandom_range(0, 39) == 0) drain_results();
      end
    end
  endtask

  // receiver alternates ready and stall runs of random length, or stays ready when pacing is off
  initial begin
    out_ready = 1'b0;
    rx_run_left = 0;
    forever begin
      @(negedge clk);
      if (!pace_enable) begin
        out_ready = 1'b1;
      end else begin
        if (rx_run_left == 0) begin
          out_ready = ~out_ready;
          rx_run_left = out_ready ? $urandom_range(1, 20) : $urandom_range(1, 12);
        end
        rx_run_left--;
      end
    end
  end

  always @(posedge clk) begin : result_check
    lpht_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: status %0d key %h slot %0d",
                   out_data.status, out_data.found_key, out_data.slot);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status || out_data.found_key !== want.found_key ||
            out_data.slot !== want.slot) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected status %0d key %h slot %0d, got status %0d key %h slot %0d",
                     want.status, want.found_key, want.slot,
                     out_data.status, out_data.found_key, out_data.slot);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    mismatch_count = 0;
    idle_cycles = 0;
    pace_enable = 1'b1;
    burst_left = 0;
    shadow_divisor = lpht_pkg::DIVISOR_RESET;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      shadow_keys[i] = '0;
      shadow_vacant[i] = 1'b1;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_operations();
    test_divisor_extremes();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lpht_pkg.sv
rtl/lpht_rem.sv
rtl/lpht_dp.sv
rtl/lpht_ctrl.sv
rtl/linear_probe_hash_table_unit.sv
tb/sv/linear_probe_hash_table_unit_tb.sv
